@@ rtl/tri2d_pkg.sv @@
// Shared types and constants for the two-anchor-pair trilateration block.
// No dependencies.
`timescale 1ns / 1ps
package tri2d_pkg;

    localparam int ANCHOR_COUNT = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int COORD_W      = 16;
    localparam int A_W          = 18;   // 2*(difference of two Q8.8 values)
    localparam int SQ_W         = 33;   // square of a 16-bit value, signed
    localparam int B_W          = 36;   // signed sum of six squares
    localparam int DET_W        = 37;   // two 18x18 products, differenced
    localparam int NUM_W        = 56;   // two 18x36 products, differenced
    localparam int QUO_W        = 56;   // quotient bits
    localparam int DIV_STAGES   = 28;   // bits resolved per cell: 2

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_A0X = 3'd0,
        REG_A0Y = 3'd1,
        REG_A1X = 3'd2,
        REG_A1Y = 3'd3,
        REG_A2X = 3'd4,
        REG_A2Y = 3'd5
    } cfg_idx_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SINGULAR = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;

    localparam logic signed [COORD_W-1:0] RST_A0X = 16'sd1682;
    localparam logic signed [COORD_W-1:0] RST_A0Y = 16'sd0;
    localparam logic signed [COORD_W-1:0] RST_A1X = 16'sd914;
    localparam logic signed [COORD_W-1:0] RST_A1Y = 16'sd0;
    localparam logic signed [COORD_W-1:0] RST_A2X = 16'sd1682;
    localparam logic signed [COORD_W-1:0] RST_A2Y = 16'sd1992;

    typedef struct packed {
        logic [15:0] dist_0;
        logic [15:0] dist_1;
        logic [15:0] dist_2;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [1:0]         status;
    } out_word_t;

    // one word in flight through the divider chain
    typedef struct packed {
        logic               vld;
        logic               sing;
        logic               neg_x;
        logic               neg_y;
        logic [NUM_W-1:0]   rem_x;
        logic [NUM_W-1:0]   rem_y;
        logic [QUO_W-1:0]   num_x;   // numerator bits still to shift in, MSB first
        logic [QUO_W-1:0]   num_y;
        logic [QUO_W-1:0]   quo_x;
        logic [QUO_W-1:0]   quo_y;
        logic [DET_W-1:0]   den;
    } div_word_t;

endpackage

@@ rtl/tri2d_div_cell.sv @@
// One cell of the restoring divider chain: resolves two quotient bits of
// both coordinates. Depends on tri2d_pkg.
`timescale 1ns / 1ps
module tri2d_div_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  tri2d_pkg::div_word_t  d_in,
    output tri2d_pkg::div_word_t  d_out
);
    tri2d_pkg::div_word_t word_reg, word_next;

    function automatic logic [tri2d_pkg::NUM_W:0] step(
        input logic [tri2d_pkg::NUM_W-1:0] rem,
        input logic                        nbit,
        input logic [tri2d_pkg::DET_W-1:0] den
    );
        logic [tri2d_pkg::NUM_W:0] sh;
        logic [tri2d_pkg::NUM_W:0] df;
        begin
            sh = {rem, nbit};
            df = sh - {{(tri2d_pkg::NUM_W+1-tri2d_pkg::DET_W){1'b0}}, den};
            if (!df[tri2d_pkg::NUM_W]) begin
                step = {1'b1, df[tri2d_pkg::NUM_W-1:0]};
            end else begin
                step = {1'b0, sh[tri2d_pkg::NUM_W-1:0]};
            end
        end
    endfunction

    always_comb begin
        logic [tri2d_pkg::NUM_W:0] r;
        word_next = d_in;
        for (int k = 0; k < 2; k++) begin
            r = step(word_next.rem_x, word_next.num_x[tri2d_pkg::QUO_W-1], word_next.den);
            word_next.rem_x = r[tri2d_pkg::NUM_W-1:0];
            word_next.quo_x = {word_next.quo_x[tri2d_pkg::QUO_W-2:0], r[tri2d_pkg::NUM_W]};
            word_next.num_x = {word_next.num_x[tri2d_pkg::QUO_W-2:0], 1'b0};
            r = step(word_next.rem_y, word_next.num_y[tri2d_pkg::QUO_W-1], word_next.den);
            word_next.rem_y = r[tri2d_pkg::NUM_W-1:0];
            word_next.quo_y = {word_next.quo_y[tri2d_pkg::QUO_W-2:0], r[tri2d_pkg::NUM_W]};
            word_next.num_y = {word_next.num_y[tri2d_pkg::QUO_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg.vld <= 1'b0;
        end else if (en) begin
            word_reg.vld <= word_next.vld;
        end
        if (en) begin
            word_reg.sing  <= word_next.sing;
            word_reg.neg_x <= word_next.neg_x;
            word_reg.neg_y <= word_next.neg_y;
            word_reg.rem_x <= word_next.rem_x;
            word_reg.rem_y <= word_next.rem_y;
            word_reg.num_x <= word_next.num_x;
            word_reg.num_y <= word_next.num_y;
            word_reg.quo_x <= word_next.quo_x;
            word_reg.quo_y <= word_next.quo_y;
            word_reg.den   <= word_next.den;
        end
    end

    assign d_out = word_reg;
endmodule

@@ rtl/tri2d_front.sv @@
// Front end: builds the linear system and Cramer numerators over three
// registered stages, then hands magnitudes to the divider. Depends on tri2d_pkg.
`timescale 1ns / 1ps
module tri2d_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_vld,
    input  tri2d_pkg::in_word_t                  in_word,
    input  logic signed [tri2d_pkg::COORD_W-1:0] a0x, a0y, a1x, a1y, a2x, a2y,
    output tri2d_pkg::div_word_t                 d_out
);
    localparam int NW = tri2d_pkg::NUM_W;
    localparam int BW = tri2d_pkg::B_W;
    localparam int AW = tri2d_pkg::A_W;
    localparam int DW = tri2d_pkg::DET_W;

    // stage 1: row coefficients and squares
    logic                 v1_reg;
    logic signed [AW-1:0] a00_reg, a01_reg, a10_reg, a11_reg;
    logic signed [BW-1:0] b0_reg, b1_reg;
    logic signed [BW-1:0] b0_next, b1_next;
    // stage 2: products
    logic                 v2_reg;
    logic signed [2*AW-1:0] p00_reg, p01_reg;
    logic signed [AW+BW-1:0] nx0_reg, nx1_reg, ny0_reg, ny1_reg;
    // stage 3: differences
    logic                 v3_reg;
    logic signed [DW-1:0] det_reg;
    logic signed [NW-1:0] nx_reg, ny_reg;

    function automatic logic signed [BW-1:0] sq_s(input logic signed [15:0] a);
        sq_s = BW'(a * a);
    endfunction
    function automatic logic signed [BW-1:0] sq_u(input logic [15:0] a);
        sq_u = BW'({1'b0, a} * {1'b0, a});
    endfunction

    always_comb begin
        logic signed [BW-1:0] rf;
        rf = sq_u(in_word.dist_2) - sq_s(a2x) - sq_s(a2y);
        b0_next = sq_s(a0x) + sq_s(a0y) + rf - sq_u(in_word.dist_0);
        b1_next = sq_s(a1x) + sq_s(a1y) + rf - sq_u(in_word.dist_1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        if (en) begin
            a00_reg <= AW'(2 * (AW'(a0x) - AW'(a2x)));
            a01_reg <= AW'(2 * (AW'(a0y) - AW'(a2y)));
            a10_reg <= AW'(2 * (AW'(a1x) - AW'(a2x)));
            a11_reg <= AW'(2 * (AW'(a1y) - AW'(a2y)));
            b0_reg  <= b0_next;
            b1_reg  <= b1_next;
            p00_reg <= a00_reg * a11_reg;
            p01_reg <= a01_reg * a10_reg;
            nx0_reg <= a11_reg * b0_reg;
            nx1_reg <= a01_reg * b1_reg;
            ny0_reg <= a00_reg * b1_reg;
            ny1_reg <= a10_reg * b0_reg;
            det_reg <= DW'(p00_reg) - DW'(p01_reg);
            nx_reg  <= NW'(nx0_reg) - NW'(nx1_reg);
            ny_reg  <= NW'(ny0_reg) - NW'(ny1_reg);
        end
    end

    // hand magnitudes to the divider; signs travel alongside
    always_comb begin
        logic          dn;
        logic [DW-1:0] dm;
        dn = det_reg[DW-1];
        dm = dn ? DW'(-det_reg) : DW'(det_reg);
        d_out.vld   = v3_reg;
        d_out.sing  = (det_reg == '0);
        d_out.neg_x = nx_reg[NW-1] ^ dn;
        d_out.neg_y = ny_reg[NW-1] ^ dn;
        d_out.rem_x = '0;
        d_out.rem_y = '0;
        d_out.num_x = nx_reg[NW-1] ? NW'(-nx_reg) : NW'(nx_reg);
        d_out.num_y = ny_reg[NW-1] ? NW'(-ny_reg) : NW'(ny_reg);
        d_out.quo_x = '0;
        d_out.quo_y = '0;
        d_out.den   = dm;
    end
endmodule

@@ rtl/trilateration_2d_three_anchors.sv @@
// Top level: anchor registers, system builder, divider cell chain and
// output saturation. Depends on tri2d_pkg, tri2d_front, tri2d_div_cell.
//
//  channel   direction  handshake            word
//  s_        in         s_valid / s_ready    in_word_t  (three distances)
//  m_        out        m_valid / m_ready    out_word_t (position, status)
//  cfg_      in         cfg_valid/cfg_ready  index, 16-bit data
//
// One word a cycle unless stalled. Stages: 3 front, 28 divider cells, 1 output.
// The whole chain advances together and holds while the output register is
// full and not taken. Synchronous active-low reset clears valid flags and
// reloads the anchor defaults.
`timescale 1ns / 1ps
module trilateration_2d_three_anchors #(
    parameter int ANCHOR_COUNT = tri2d_pkg::ANCHOR_COUNT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  tri2d_pkg::in_word_t                  s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output tri2d_pkg::out_word_t                 m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tri2d_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [15:0]                          cfg_data
);
    localparam int NS = tri2d_pkg::DIV_STAGES;
    localparam int QW = tri2d_pkg::QUO_W;

    logic signed [15:0] a0x_reg, a0y_reg, a1x_reg, a1y_reg, a2x_reg, a2y_reg;
    logic en;
    tri2d_pkg::div_word_t chain [0:NS];
    tri2d_pkg::out_word_t out_reg, out_next;
    logic out_vld_reg;

    assign cfg_ready = (ANCHOR_COUNT == 3);
    assign en        = !out_vld_reg || m_ready;
    assign s_ready   = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a0x_reg <= tri2d_pkg::RST_A0X;
            a0y_reg <= tri2d_pkg::RST_A0Y;
            a1x_reg <= tri2d_pkg::RST_A1X;
            a1y_reg <= tri2d_pkg::RST_A1Y;
            a2x_reg <= tri2d_pkg::RST_A2X;
            a2y_reg <= tri2d_pkg::RST_A2Y;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                tri2d_pkg::REG_A0X: a0x_reg <= cfg_data;
                tri2d_pkg::REG_A0Y: a0y_reg <= cfg_data;
                tri2d_pkg::REG_A1X: a1x_reg <= cfg_data;
                tri2d_pkg::REG_A1Y: a1y_reg <= cfg_data;
                tri2d_pkg::REG_A2X: a2x_reg <= cfg_data;
                tri2d_pkg::REG_A2Y: a2y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    tri2d_front u_front (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(s_valid), .in_word(s_data),
        .a0x(a0x_reg), .a0y(a0y_reg), .a1x(a1x_reg),
        .a1y(a1y_reg), .a2x(a2x_reg), .a2y(a2y_reg),
        .d_out(chain[0])
    );

    for (genvar g = 0; g < NS; g++) begin : g_cell
        tri2d_div_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .d_in(chain[g]), .d_out(chain[g+1])
        );
    end

    // sign restore, clamp and status; singular results are forced to zero
    always_comb begin
        logic [QW-1:0] qx, qy;
        logic signed [QW:0] sx, sy;
        logic sat;
        qx = chain[NS].quo_x;
        qy = chain[NS].quo_y;
        sx = chain[NS].neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
        sy = chain[NS].neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
        sat = 1'b0;
        out_next.pos_x = sx[15:0];
        out_next.pos_y = sy[15:0];
        if (sx > 32767) begin
            out_next.pos_x = 16'sh7FFF; sat = 1'b1;
        end else if (sx < -32768) begin
            out_next.pos_x = 16'sh8000; sat = 1'b1;
        end
        if (sy > 32767) begin
            out_next.pos_y = 16'sh7FFF; sat = 1'b1;
        end else if (sy < -32768) begin
            out_next.pos_y = 16'sh8000; sat = 1'b1;
        end
        out_next.status = sat ? tri2d_pkg::ST_SAT : tri2d_pkg::ST_OK;
        if (chain[NS].sing) begin
            out_next.pos_x  = '0;
            out_next.pos_y  = '0;
            out_next.status = tri2d_pkg::ST_SINGULAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= chain[NS].vld;
        end
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;
endmodule

@@ rtl/tri2d_checker.sv @@
// Port-level checks for the trilateration block, bound to the top level.
// Depends on tri2d_pkg.
`timescale 1ns / 1ps
module tri2d_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input tri2d_pkg::out_word_t m_data
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word dropped or changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= tri2d_pkg::ST_SAT)
        else $error("undefined status code");

    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == tri2d_pkg::ST_SINGULAR |->
        m_data.pos_x == 0 && m_data.pos_y == 0)
        else $error("singular result with nonzero position");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");
endmodule

bind trilateration_2d_three_anchors tri2d_checker u_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
